[rtl/mpab_pkg.sv]
`timescale 1ns / 1ps

package mpab_pkg;

    localparam int NODES    = 256;
    localparam int ALPHABET = 16;
    localparam int NODE_W   = $clog2(NODES);
    localparam int SYM_W    = $clog2(ALPHABET);
    localparam int CNT_W    = NODE_W + 1;
    localparam int ADDR_W   = NODE_W + SYM_W;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_BUILD = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_BUILT = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_ADD_RD,
        S_ADD_UPD,
        S_RD_CHK,
        S_RD_G,
        S_RD_M,
        S_B_INIT,
        S_B_RRD,
        S_B_RWR,
        S_B_POP,
        S_B_V,
        S_B_FV,
        S_B_CRD,
        S_B_CCHK,
        S_B_F,
        S_B_M,
        S_B_GRD,
        S_B_GWR,
        S_B_FIN,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_ACCEPT,
        CMD_ADD_RD,
        CMD_ADD_UPD,
        CMD_RD_CHK,
        CMD_RD_MREQ,
        CMD_RD_MGET,
        CMD_B_INIT,
        CMD_B_RRD,
        CMD_B_RWR,
        CMD_B_POP,
        CMD_B_V,
        CMD_B_FV,
        CMD_B_CRD,
        CMD_B_CCHK,
        CMD_B_F,
        CMD_B_M,
        CMD_B_GRD,
        CMD_B_GWR,
        CMD_B_FIN,
        CMD_DONE
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        t_op  op;
        logic i_last;
        logic j_last;
        logic q_empty;
        logic child_hit;
        logic read_ok;
        logic out_free;
    } t_dp_status;

endpackage

[rtl/mpab_ctrl.sv]
`timescale 1ns / 1ps

module mpab_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output mpab_pkg::t_cmd      o_cmd,
    input  mpab_pkg::t_dp_status i_st
);

    mpab_pkg::t_state r_state;
    mpab_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpab_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = mpab_pkg::CMD_NONE;
        o_ready = 1'b0;
        unique case (r_state)
            mpab_pkg::S_CLEAR: begin
                o_cmd = mpab_pkg::CMD_CLEAR;
                if (i_st.clr_last) n_state = mpab_pkg::S_IDLE;
            end
            mpab_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd   = mpab_pkg::CMD_ACCEPT;
                    n_state = mpab_pkg::S_DISPATCH;
                end
            end
            mpab_pkg::S_DISPATCH: begin
                unique case (i_st.op)
                    mpab_pkg::OP_ADD:   n_state = mpab_pkg::S_ADD_RD;
                    mpab_pkg::OP_BUILD: n_state = mpab_pkg::S_B_INIT;
                    mpab_pkg::OP_READ:  n_state = mpab_pkg::S_RD_CHK;
                    default:            n_state = mpab_pkg::S_DONE;
                endcase
            end
            mpab_pkg::S_ADD_RD: begin
                o_cmd   = mpab_pkg::CMD_ADD_RD;
                n_state = mpab_pkg::S_ADD_UPD;
            end
            mpab_pkg::S_ADD_UPD: begin
                o_cmd   = mpab_pkg::CMD_ADD_UPD;
                n_state = mpab_pkg::S_DONE;
            end
            mpab_pkg::S_RD_CHK: begin
                o_cmd   = mpab_pkg::CMD_RD_CHK;
                n_state = i_st.read_ok ? mpab_pkg::S_RD_G : mpab_pkg::S_DONE;
            end
            mpab_pkg::S_RD_G: begin
                o_cmd   = mpab_pkg::CMD_RD_MREQ;
                n_state = mpab_pkg::S_RD_M;
            end
            mpab_pkg::S_RD_M: begin
                o_cmd   = mpab_pkg::CMD_RD_MGET;
                n_state = mpab_pkg::S_DONE;
            end
            mpab_pkg::S_B_INIT: begin
                o_cmd   = mpab_pkg::CMD_B_INIT;
                n_state = mpab_pkg::S_B_RRD;
            end
            mpab_pkg::S_B_RRD: begin
                o_cmd   = mpab_pkg::CMD_B_RRD;
                n_state = mpab_pkg::S_B_RWR;
            end
            mpab_pkg::S_B_RWR: begin
                o_cmd   = mpab_pkg::CMD_B_RWR;
                n_state = i_st.i_last ? mpab_pkg::S_B_POP : mpab_pkg::S_B_RRD;
            end
            mpab_pkg::S_B_POP: begin
                o_cmd   = mpab_pkg::CMD_B_POP;
                n_state = i_st.q_empty ? mpab_pkg::S_B_FIN : mpab_pkg::S_B_V;
            end
            mpab_pkg::S_B_V: begin
                o_cmd   = mpab_pkg::CMD_B_V;
                n_state = mpab_pkg::S_B_FV;
            end
            mpab_pkg::S_B_FV: begin
                o_cmd   = mpab_pkg::CMD_B_FV;
                n_state = mpab_pkg::S_B_CRD;
            end
            mpab_pkg::S_B_CRD: begin
                o_cmd   = mpab_pkg::CMD_B_CRD;
                n_state = mpab_pkg::S_B_CCHK;
            end
            mpab_pkg::S_B_CCHK: begin
                o_cmd = mpab_pkg::CMD_B_CCHK;
                priority if (i_st.child_hit) n_state = mpab_pkg::S_B_F;
                else if (i_st.i_last)        n_state = mpab_pkg::S_B_POP;
                else                         n_state = mpab_pkg::S_B_CRD;
            end
            mpab_pkg::S_B_F: begin
                o_cmd   = mpab_pkg::CMD_B_F;
                n_state = mpab_pkg::S_B_M;
            end
            mpab_pkg::S_B_M: begin
                o_cmd   = mpab_pkg::CMD_B_M;
                n_state = mpab_pkg::S_B_GRD;
            end
            mpab_pkg::S_B_GRD: begin
                o_cmd   = mpab_pkg::CMD_B_GRD;
                n_state = mpab_pkg::S_B_GWR;
            end
            mpab_pkg::S_B_GWR: begin
                o_cmd = mpab_pkg::CMD_B_GWR;
                priority if (!i_st.j_last) n_state = mpab_pkg::S_B_GRD;
                else if (i_st.i_last)      n_state = mpab_pkg::S_B_POP;
                else                       n_state = mpab_pkg::S_B_CRD;
            end
            mpab_pkg::S_B_FIN: begin
                o_cmd   = mpab_pkg::CMD_B_FIN;
                n_state = mpab_pkg::S_DONE;
            end
            mpab_pkg::S_DONE: begin
                o_cmd = mpab_pkg::CMD_DONE;
                if (i_st.out_free) n_state = mpab_pkg::S_IDLE;
            end
            default: n_state = mpab_pkg::S_IDLE;
        endcase
    end

endmodule

[rtl/mpab_dp.sv]
`timescale 1ns / 1ps

module mpab_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mpab_pkg::t_cmd                    i_cmd,
    output mpab_pkg::t_dp_status              o_st,
    input  logic [1:0]                        i_op,
    input  logic [mpab_pkg::SYM_W-1:0]        i_sym,
    input  logic                              i_wend,
    input  logic [mpab_pkg::NODE_W-1:0]       i_node,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mpab_pkg::NODE_W-1:0]       o_next,
    output logic                              o_match,
    output logic [1:0]                        o_status
);

    localparam int NW = mpab_pkg::NODE_W;
    localparam int SW = mpab_pkg::SYM_W;
    localparam int AW = mpab_pkg::ADDR_W;
    localparam int CW = mpab_pkg::CNT_W;
    localparam int DEPTH = mpab_pkg::NODES * mpab_pkg::ALPHABET;

    // A child entry of zero means no child: the root is never anybody's child.
    logic [NW-1:0] child_mem [DEPTH];
    logic [NW-1:0] goto_mem  [DEPTH];
    logic [NW-1:0] fail_mem  [mpab_pkg::NODES];
    logic          match_mem [mpab_pkg::NODES];
    logic [NW-1:0] queue_mem [mpab_pkg::NODES];
    logic          term_mem  [mpab_pkg::NODES];

    logic [AW-1:0] r_clr;
    logic [CW-1:0] r_count;
    logic [NW-1:0] r_cursor;
    logic          r_built;
    logic [1:0]    r_op;
    logic [SW-1:0] r_sym;
    logic          r_wend;
    logic [NW-1:0] r_node;
    logic [SW-1:0] r_i;
    logic [SW-1:0] r_j;
    logic [CW-1:0] r_head;
    logic [CW-1:0] r_tail;
    logic [NW-1:0] r_v;
    logic [NW-1:0] r_fv;
    logic [NW-1:0] r_u;
    logic [NW-1:0] r_f;
    logic [NW-1:0] r_res_next;
    logic          r_res_match;
    logic [1:0]    r_res_status;
    logic          r_out_valid;
    logic [NW-1:0] r_out_next;
    logic          r_out_match;
    logic [1:0]    r_out_status;

    logic [NW-1:0] r_c_rd;
    logic [NW-1:0] r_g_rd;
    logic [NW-1:0] r_f_rd;
    logic          r_m_rd;
    logic [NW-1:0] r_q_rd;
    logic          r_t_rd;

    logic [AW-1:0] c_raddr, g_raddr, c_waddr, g_waddr;
    logic [NW-1:0] c_wdata, g_wdata, f_raddr, f_waddr, f_wdata;
    logic [NW-1:0] m_raddr, m_waddr, q_waddr, q_wdata, f_next, new_node, cur_after;
    logic [NW-1:0] t_waddr;
    logic          c_we, g_we, f_we, m_we, m_wdata, q_we, t_we, t_wdata;
    logic          c_hit, room, add_ok, out_free, load_out, i_last, j_last;

    assign c_hit    = (r_c_rd != '0);
    assign room     = (r_count < CW'(mpab_pkg::NODES));
    assign add_ok   = c_hit || room;
    assign new_node = c_hit ? r_c_rd : r_count[NW-1:0];
    assign cur_after = r_wend ? '0 : (add_ok ? new_node : r_cursor);
    assign f_next   = (r_v == '0) ? '0 : r_g_rd;
    assign out_free = !r_out_valid || i_ready;
    assign load_out = (i_cmd == mpab_pkg::CMD_DONE) && out_free;
    assign i_last   = (r_i == SW'(mpab_pkg::ALPHABET - 1));
    assign j_last   = (r_j == SW'(mpab_pkg::ALPHABET - 1));

    always_comb begin
        c_raddr = {r_u, r_j};
        g_raddr = {r_f, r_j};
        unique case (i_cmd)
            mpab_pkg::CMD_ADD_RD: c_raddr = {r_cursor, r_sym};
            mpab_pkg::CMD_B_RRD:  c_raddr = {NW'(0), r_i};
            mpab_pkg::CMD_B_CRD:  c_raddr = {r_v, r_i};
            default:              c_raddr = {r_u, r_j};
        endcase
        unique case (i_cmd)
            mpab_pkg::CMD_RD_CHK: g_raddr = {r_node, r_sym};
            mpab_pkg::CMD_B_CCHK: g_raddr = {r_fv, r_i};
            default:              g_raddr = {r_f, r_j};
        endcase
        c_we    = 1'b0;
        c_waddr = {r_cursor, r_sym};
        c_wdata = r_count[NW-1:0];
        if (i_cmd == mpab_pkg::CMD_CLEAR) begin
            c_we    = 1'b1;
            c_waddr = r_clr;
            c_wdata = '0;
        end else if (i_cmd == mpab_pkg::CMD_ADD_UPD) begin
            c_we = !c_hit && room;
        end
        // The clearing pass also zeroes the terminal flags on its way through.
        t_we    = (i_cmd == mpab_pkg::CMD_CLEAR)
               || ((i_cmd == mpab_pkg::CMD_ADD_UPD) && add_ok && r_wend);
        t_waddr = (i_cmd == mpab_pkg::CMD_CLEAR) ? r_clr[NW-1:0] : new_node;
        t_wdata = (i_cmd != mpab_pkg::CMD_CLEAR);
        g_we    = (i_cmd == mpab_pkg::CMD_B_RWR) || (i_cmd == mpab_pkg::CMD_B_GWR);
        g_waddr = (i_cmd == mpab_pkg::CMD_B_RWR) ? {NW'(0), r_i} : {r_u, r_j};
        g_wdata = (i_cmd == mpab_pkg::CMD_B_RWR || c_hit) ? r_c_rd : r_g_rd;
        f_raddr = r_q_rd;
        f_we    = (i_cmd == mpab_pkg::CMD_B_F);
        f_waddr = r_u;
        f_wdata = f_next;
        m_raddr = (i_cmd == mpab_pkg::CMD_RD_MREQ) ? r_g_rd : f_next;
        m_we    = (i_cmd == mpab_pkg::CMD_B_INIT) || (i_cmd == mpab_pkg::CMD_B_M);
        m_waddr = (i_cmd == mpab_pkg::CMD_B_INIT) ? '0 : r_u;
        m_wdata = (i_cmd == mpab_pkg::CMD_B_M) && (r_m_rd || r_t_rd);
        q_we    = (i_cmd == mpab_pkg::CMD_B_INIT)
               || ((i_cmd == mpab_pkg::CMD_B_GWR) && j_last);
        q_waddr = (i_cmd == mpab_pkg::CMD_B_INIT) ? '0 : r_tail[NW-1:0];
        q_wdata = (i_cmd == mpab_pkg::CMD_B_INIT) ? '0 : r_u;
    end

    always_ff @(posedge i_clk) begin
        if (c_we) child_mem[c_waddr] <= c_wdata;
        if (g_we) goto_mem[g_waddr] <= g_wdata;
        if (f_we) fail_mem[f_waddr] <= f_wdata;
        if (m_we) match_mem[m_waddr] <= m_wdata;
        if (q_we) queue_mem[q_waddr] <= q_wdata;
        if (t_we) term_mem[t_waddr] <= t_wdata;
        r_c_rd <= child_mem[c_raddr];
        r_g_rd <= goto_mem[g_raddr];
        r_f_rd <= fail_mem[f_raddr];
        r_m_rd <= match_mem[m_raddr];
        r_q_rd <= queue_mem[r_head[NW-1:0]];
        r_t_rd <= term_mem[r_u];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_count     <= CW'(1);
            r_cursor    <= '0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
        end else begin
            if (i_cmd == mpab_pkg::CMD_CLEAR) r_clr <= r_clr + AW'(1);
            if (i_cmd == mpab_pkg::CMD_ADD_UPD) begin
                r_built  <= 1'b0;
                r_cursor <= cur_after;
                if (!c_hit && room) r_count <= r_count + CW'(1);
            end
            if (i_cmd == mpab_pkg::CMD_B_FIN) r_built <= 1'b1;
            if (i_cmd == mpab_pkg::CMD_B_INIT) begin
                r_head <= '0;
                r_tail <= CW'(1);
            end
            if (i_cmd == mpab_pkg::CMD_B_POP && r_head != r_tail) r_head <= r_head + CW'(1);
            if (i_cmd == mpab_pkg::CMD_B_GWR && j_last) r_tail <= r_tail + CW'(1);
            if (load_out)     r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            mpab_pkg::CMD_ACCEPT: begin
                r_op         <= i_op;
                r_sym        <= i_sym;
                r_wend       <= i_wend;
                r_node       <= i_node;
                r_res_next   <= r_cursor;
                r_res_match  <= 1'b0;
                r_res_status <= mpab_pkg::ST_OK;
            end
            mpab_pkg::CMD_ADD_UPD: begin
                r_res_next   <= cur_after;
                r_res_status <= add_ok ? mpab_pkg::ST_OK : mpab_pkg::ST_FULL;
            end
            mpab_pkg::CMD_RD_CHK: begin
                r_res_next   <= '0;
                r_res_status <= r_built ? mpab_pkg::ST_OK : mpab_pkg::ST_NOT_BUILT;
            end
            mpab_pkg::CMD_RD_MREQ: r_res_next <= r_g_rd;
            mpab_pkg::CMD_RD_MGET: r_res_match <= r_m_rd;
            mpab_pkg::CMD_B_INIT:  r_i <= '0;
            mpab_pkg::CMD_B_RWR:   r_i <= r_i + SW'(1);
            mpab_pkg::CMD_B_V:     r_v <= r_q_rd;
            mpab_pkg::CMD_B_FV: begin
                r_fv <= r_f_rd;
                r_i  <= '0;
            end
            mpab_pkg::CMD_B_CCHK: begin
                r_u <= r_c_rd;
                if (!c_hit) r_i <= r_i + SW'(1);
            end
            mpab_pkg::CMD_B_F: begin
                r_f <= f_next;
                r_j <= '0;
            end
            mpab_pkg::CMD_B_GWR: begin
                r_j <= r_j + SW'(1);
                if (j_last) r_i <= r_i + SW'(1);
            end
            default: begin
            end
        endcase
        if (load_out) begin
            r_out_next   <= r_res_next;
            r_out_match  <= r_res_match;
            r_out_status <= r_res_status;
        end
    end

    assign o_st.clr_last  = (r_clr == {AW{1'b1}});
    assign o_st.op        = mpab_pkg::t_op'(r_op);
    assign o_st.i_last    = i_last;
    assign o_st.j_last    = j_last;
    assign o_st.q_empty   = (r_head == r_tail);
    assign o_st.child_hit = c_hit;
    assign o_st.read_ok   = r_built && ({1'b0, r_node} < r_count);
    assign o_st.out_free  = out_free;

    assign o_valid  = r_out_valid;
    assign o_next   = r_out_next;
    assign o_match  = r_out_match;
    assign o_status = r_out_status;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(1)) && (r_count <= CW'(mpab_pkg::NODES)))
        else $error("node count out of range");

    a_cursor_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cursor} < r_count)
        else $error("insertion cursor points past allocated nodes");

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("breadth-first queue head passed its tail");

endmodule

[rtl/multi_pattern_automaton_builder.sv]
`timescale 1ns / 1ps

// Aho-Corasick automaton builder. Add words insert one pattern symbol each
// (tlast marks the last symbol of a pattern), a build word computes failure
// links, match flags and the full goto table, and a read word returns the goto
// target and match flag of a node and symbol; every input word yields exactly
// one output word. One word is worked at a time by a sequencer over on-chip
// tables. A read is refused when the automaton is not built or the node is out
// of range. The result is presented as the block becomes ready for the next
// word. After reset a clearing pass over the child table and the terminal flags
// holds s_axis_tready low.
module multi_pattern_automaton_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // symbol[3:0], node[11:4], zero[15:12]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    input  logic        s_axis_tlast,   // word_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // next_node[7:0], match[8], zero[15:9]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    mpab_pkg::t_cmd       cmd;
    mpab_pkg::t_dp_status st;
    logic [mpab_pkg::NODE_W-1:0] next_node;
    logic match;

    mpab_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .o_cmd   (cmd),
        .i_st    (st)
    );

    mpab_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_st     (st),
        .i_op     (s_axis_tuser),
        .i_sym    (s_axis_tdata[3:0]),
        .i_wend   (s_axis_tlast),
        .i_node   (s_axis_tdata[11:4]),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_next   (next_node),
        .o_match  (match),
        .o_status (m_axis_tuser)
    );

    assign m_axis_tdata = {7'd0, match, next_node};

endmodule

[bench/multi_pattern_automaton_builder_tb.sv]
`timescale 1ns / 1ps

module multi_pattern_automaton_builder_tb;

    localparam int IDLE_LIMIT = 100000;
    localparam int RANDOM_WORDS = 1830;
    localparam int NODES = mpab_pkg::NODES;
    localparam int ALPHABET = mpab_pkg::ALPHABET;

    typedef struct packed {
        logic [7:0]        next_node;
        logic              match;
        mpab_pkg::t_status status;
    } t_answer;

    typedef struct packed {
        mpab_pkg::t_op     op;
        logic [3:0]        sym;
        logic              wend;
        logic [7:0]        node;
        logic              typed;
        logic [7:0]        next_node;
        logic              match;
        mpab_pkg::t_status status;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    multi_pattern_automaton_builder dut (.*);

    // Trie and automaton as the testbench sees them.
    bit  kid_valid [NODES*ALPHABET];
    int  kid_node  [NODES*ALPHABET];
    int  jump      [NODES*ALPHABET];
    int  fail_to   [NODES];
    bit  ends_here [NODES];
    bit  hits      [NODES];
    int  bfs       [NODES];
    int  used_nodes;
    int  cursor;
    bit  is_built;

    t_answer pending_answers[$];
    int  errors, idle_cycles, words_in, words_out;
    int  n_add, n_build, n_read, n_full, n_match;
    bit  steady_rx;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    function automatic void build_automaton_model();
        int head, tail, v, u, f, k;
        head = 0;
        tail = 0;
        fail_to[0] = 0;
        hits[0] = ends_here[0];
        for (int i = 0; i < ALPHABET; i++) jump[i] = kid_valid[i] ? kid_node[i] : 0;
        bfs[tail++] = 0;
        while (head < tail && head < NODES) begin
            v = bfs[head++];
            for (int i = 0; i < ALPHABET; i++) begin
                if (!kid_valid[v*ALPHABET+i]) continue;
                u = kid_node[v*ALPHABET+i];
                f = (v != 0) ? jump[fail_to[v]*ALPHABET+i] : 0;
                fail_to[u] = f;
                hits[u] = hits[f] | ends_here[u];
                for (int j = 0; j < ALPHABET; j++) begin
                    k = u*ALPHABET + j;
                    jump[k] = kid_valid[k] ? kid_node[k] : jump[f*ALPHABET+j];
                end
                if (tail < NODES) bfs[tail++] = u;
            end
        end
        is_built = 1'b1;
    endfunction

    // Advances the model by one word and returns the answer it should give.
    function automatic t_answer predict_answer(mpab_pkg::t_op op, int sym, bit wend,
                                               int node);
        t_answer a;
        int k;
        a = '{next_node: cursor[7:0], match: 1'b0, status: mpab_pkg::ST_OK};
        case (op)
            mpab_pkg::OP_ADD: begin
                k = cursor*ALPHABET + sym;
                is_built = 1'b0;
                n_add++;
                if (!kid_valid[k] && used_nodes >= NODES) begin
                    a.status = mpab_pkg::ST_FULL;
                    n_full++;
                end else begin
                    if (!kid_valid[k]) begin
                        for (int i = 0; i < ALPHABET; i++)
                            kid_valid[used_nodes*ALPHABET+i] = 1'b0;
                        ends_here[used_nodes] = 1'b0;
                        kid_node[k] = used_nodes;
                        kid_valid[k] = 1'b1;
                        used_nodes++;
                    end
                    cursor = kid_node[k];
                    if (wend) ends_here[cursor] = 1'b1;
                end
                if (wend) cursor = 0;
                a.next_node = cursor[7:0];
            end
            mpab_pkg::OP_BUILD: begin
                build_automaton_model();
                n_build++;
            end
            mpab_pkg::OP_READ: begin
                n_read++;
                a.next_node = 8'd0;
                if (!is_built) begin
                    a.status = mpab_pkg::ST_NOT_BUILT;
                end else if (node < used_nodes) begin
                    a.next_node = jump[node*ALPHABET+sym][7:0];
                    a.match = hits[jump[node*ALPHABET+sym]];
                    n_match += a.match;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The valid stays high after a handshake until the next call's first falling edge.
    task automatic send_word(input mpab_pkg::t_op op, input int sym, input bit wend,
                             input int node, input bit typed, input t_answer typed_answer,
                             input bit gaps);
        int g;
        t_answer a;
        g = gaps ? gap_len() : 0;
        @(negedge i_clk);
        if (g > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tlast  = wend;
        s_axis_tdata  = {4'd0, node[7:0], sym[3:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        a = predict_answer(op, sym, wend, node);
        if (typed && a != typed_answer)
            $display("note: typed answer differs from prediction for op %s", op.name());
        pending_answers.push_back(typed ? typed_answer : a);
        words_in++;
    endtask

    task automatic send_random(input mpab_pkg::t_op op, input int sym, input bit wend,
                               input int node);
        send_word(op, sym, wend, node, 1'b0, '0, 1'b1);
    endtask

    // Receiver back-pressure.
    initial begin
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0 && !steady_rx) begin
                m_axis_tready = 1'b0;
                stall--;
            end else begin
                m_axis_tready = 1'b1;
                stall = 0;
                if ($urandom_range(0, 3) == 0) stall = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            words_out++;
            if (pending_answers.size() == 0) begin
                report($sformatf("unexpected word %h/%h", m_axis_tdata, m_axis_tuser));
            end else begin
                want = pending_answers.pop_front();
                if (m_axis_tdata[7:0] != want.next_node)
                    report($sformatf("next_node %0d, want %0d", m_axis_tdata[7:0],
                                     want.next_node));
                if (m_axis_tdata[8] != want.match)
                    report($sformatf("match %0d, want %0d", m_axis_tdata[8], want.match));
                if (m_axis_tdata[15:9] != 7'd0)
                    report("nonzero padding in output word");
                if (m_axis_tuser != want.status)
                    report($sformatf("status %0d, want %0d", m_axis_tuser, want.status));
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    t_row directed [20] = '{
        '{mpab_pkg::OP_READ,  4'd3,  1'b0, 8'd0,   1'b1, 8'd0, 1'b0, mpab_pkg::ST_NOT_BUILT},
        '{mpab_pkg::OP_NOP,   4'd15, 1'b1, 8'd255, 1'b1, 8'd0, 1'b0, mpab_pkg::ST_OK},
        '{mpab_pkg::OP_BUILD, 4'd0,  1'b0, 8'd0,   1'b1, 8'd0, 1'b0, mpab_pkg::ST_OK},
        '{mpab_pkg::OP_READ,  4'd15, 1'b0, 8'd0,   1'b1, 8'd0, 1'b0, mpab_pkg::ST_OK},
        '{mpab_pkg::OP_READ,  4'd0,  1'b0, 8'd255, 1'b1, 8'd0, 1'b0, mpab_pkg::ST_OK},
        '{mpab_pkg::OP_ADD,   4'd0,  1'b0, 8'd0,   1'b1, 8'd1, 1'b0, mpab_pkg::ST_OK},
        '{mpab_pkg::OP_ADD,   4'd15, 1'b1, 8'd255, 1'b1, 8'd0, 1'b0, mpab_pkg::ST_OK},
        '{mpab_pkg::OP_ADD,   4'd15, 1'b1, 8'd0,   1'b1, 8'd0, 1'b0, mpab_pkg::ST_OK},
        '{mpab_pkg::OP_ADD,   4'd0,  1'b0, 8'd170, 1'b1, 8'd1, 1'b0, mpab_pkg::ST_OK},
        '{mpab_pkg::OP_ADD,   4'd15, 1'b1, 8'd85,  1'b1, 8'd0, 1'b0, mpab_pkg::ST_OK},
        '{mpab_pkg::OP_READ,  4'd15, 1'b0, 8'd1,   1'b1, 8'd0, 1'b0, mpab_pkg::ST_NOT_BUILT},
        '{mpab_pkg::OP_BUILD, 4'd0,  1'b0, 8'd0,   1'b1, 8'd0, 1'b0, mpab_pkg::ST_OK},
        '{mpab_pkg::OP_READ,  4'd15, 1'b0, 8'd1,   1'b1, 8'd2, 1'b1, mpab_pkg::ST_OK},
        '{mpab_pkg::OP_READ,  4'd15, 1'b0, 8'd2,   1'b0, 8'd0, 1'b0, mpab_pkg::ST_OK},
        '{mpab_pkg::OP_READ,  4'd0,  1'b0, 8'd3,   1'b0, 8'd0, 1'b0, mpab_pkg::ST_OK},
        '{mpab_pkg::OP_READ,  4'd7,  1'b0, 8'd4,   1'b1, 8'd0, 1'b0, mpab_pkg::ST_OK},
        '{mpab_pkg::OP_ADD,   4'd10, 1'b0, 8'd15,  1'b0, 8'd0, 1'b0, mpab_pkg::ST_OK},
        '{mpab_pkg::OP_NOP,   4'd5,  1'b0, 8'd240, 1'b0, 8'd0, 1'b0, mpab_pkg::ST_OK},
        '{mpab_pkg::OP_BUILD, 4'd9,  1'b1, 8'd9,   1'b0, 8'd0, 1'b0, mpab_pkg::ST_OK},
        '{mpab_pkg::OP_READ,  4'd0,  1'b0, 8'd0,   1'b0, 8'd0, 1'b0, mpab_pkg::ST_OK}
    };

    initial begin
        int since_build, len, drained;
        bit narrow;
        t_answer typed;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        steady_rx = 1'b0;
        errors = 0; idle_cycles = 0; words_in = 0; words_out = 0;
        n_add = 0; n_build = 0; n_read = 0; n_full = 0; n_match = 0;
        for (int i = 0; i < NODES*ALPHABET; i++) kid_valid[i] = 1'b0;
        for (int i = 0; i < NODES; i++) ends_here[i] = 1'b0;
        used_nodes = 1;
        cursor = 0;
        is_built = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[r]) begin
            typed = '{next_node: directed[r].next_node, match: directed[r].match,
                      status: directed[r].status};
            send_word(directed[r].op, directed[r].sym, directed[r].wend, directed[r].node,
                      directed[r].typed, typed, 1'b1);
        end

        // Hold the sender until the block has answered everything.
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        wait (pending_answers.size() == 0);

        since_build = 0;
        while (words_in < RANDOM_WORDS) begin
            // Some phases run without any receiver stalls.
            steady_rx = ($urandom_range(0, 5) == 0);
            len = $urandom_range(0, 99);
            if (since_build > 70 || len < 6) begin
                send_random(mpab_pkg::OP_BUILD, $urandom_range(0, 15),
                            1'($urandom_range(0, 1)), $urandom_range(0, 255));
                since_build = 0;
                repeat ($urandom_range(10, 30)) begin
                    if ($urandom_range(0, 9) == 0)
                        send_random(mpab_pkg::OP_READ, $urandom_range(0, 15), 1'b0,
                                    $urandom_range(0, 255));
                    else
                        send_random(mpab_pkg::OP_READ, $urandom_range(0, 15),
                                    1'($urandom_range(0, 1)),
                                    $urandom_range(0, used_nodes - 1));
                end
            end else if (len < 80) begin
                // A pattern; a narrow alphabet makes shared prefixes and failure chains.
                narrow = 1'($urandom_range(0, 1));
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    send_random(mpab_pkg::OP_ADD,
                                narrow ? $urandom_range(0, 2) : $urandom_range(0, 15),
                                (i == len - 1) && ($urandom_range(0, 9) != 0),
                                $urandom_range(0, 255));
                since_build += len;
            end else if (len < 88) begin
                send_random(mpab_pkg::OP_NOP, $urandom_range(0, 15),
                            1'($urandom_range(0, 1)), $urandom_range(0, 255));
                since_build++;
            end else begin
                send_random(mpab_pkg::OP_READ, $urandom_range(0, 15),
                            1'($urandom_range(0, 1)), $urandom_range(0, 255));
                since_build++;
            end
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        steady_rx = 1'b0;
        wait (pending_answers.size() == 0);
        repeat (40) @(posedge i_clk);

        $display("%0d words in, %0d out: %0d adds (%0d dropped on a full trie), %0d builds,",
                 words_in, words_out, n_add, n_full, n_build);
        $display("%0d reads of which %0d hit a matching state; trie holds %0d nodes",
                 n_read, n_match, used_nodes);
        drained = pending_answers.size();
        if (errors == 0 && drained == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
